// File: rtl/sbrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigma band run detector package
// Shared types, register indexes, band codes and reset values for the
// front classifier, the decoupling queue and the run tracking back end.
// ----------------------------------------------------------------------------
package sbrd_pkg;

   // Configuration register indexes.
   localparam logic [2:0] RegMeanLevel = 3'd0;
   localparam logic [2:0] RegBandSigma = 3'd1;
   localparam logic [2:0] RegBand1Limit = 3'd2;
   localparam logic [2:0] RegBand2Limit = 3'd3;
   localparam logic [2:0] RegBand3Limit = 3'd4;

   // Band codes as they appear in the result.
   localparam logic [1:0] BandOne = 2'd0;
   localparam logic [1:0] BandTwo = 2'd1;
   localparam logic [1:0] BandThree = 2'd2;
   localparam logic [1:0] BandOutlier = 2'd3;

   // Reset values of the run limits.
   localparam logic [15:0] Band1LimitReset = 16'd50;
   localparam logic [15:0] Band2LimitReset = 16'd15;
   localparam logic [15:0] Band3LimitReset = 16'd6;

   // Depth of the queues between the front, the back and the result side.
   localparam int QueueDepth = 2;
   localparam int QueuePtrW = $clog2(QueueDepth);
   localparam int QueueCntW = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic signed [31:0] mean_level;
      logic [30:0]        band_sigma;
      logic [15:0]        band1_run_limit;
      logic [15:0]        band2_run_limit;
      logic [15:0]        band3_run_limit;
   } cfg_type;

   // A classified request travelling from the front to the back.
   typedef struct packed {
      logic [31:0]        sample_time;
      logic signed [31:0] sample_value;
      logic               keep_band;
      logic [1:0]         band;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef struct packed {
      logic [31:0]        run_start;
      logic [31:0]        run_end;
      logic [1:0]         run_kind;
      logic [31:0]        run_readings;
      logic signed [47:0] run_total;
   } result_type;

endpackage

// File: rtl/sbrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigma band run detector front end
// Accepts requests and places each sample in a band around the mean, or
// flags it as lying on the outer bound so that the back end keeps its band.
// ----------------------------------------------------------------------------
module sbrd_front (
   input  sbrd_pkg::cfg_type   cfg,
   input  logic                push,
   input  logic [31:0]         req_sample_time,
   input  logic signed [31:0]  req_sample_value,
   input  sbrd_pkg::qstat_type q_stat,
   output logic                q_push,
   output sbrd_pkg::entry_type q_entry
);
   import sbrd_pkg::*;

   logic signed [34:0] mean_x;
   logic signed [34:0] value_x;
   logic signed [34:0] dist1;
   logic signed [34:0] dist2;
   logic signed [34:0] dist3;
   logic               in1;
   logic               in2;
   logic               in3;
   logic               beyond3;

   // Band half-widths of one, two and three sigma, wide enough not to wrap.
   assign dist1 = signed'({4'd0, cfg.band_sigma});
   assign dist2 = dist1 <<< 1;
   assign dist3 = dist1 + dist2;
   assign mean_x = 35'(cfg.mean_level);
   assign value_x = 35'(req_sample_value);

   // Strict comparisons against each pair of bounds.
   assign in1 = (mean_x - dist1 < value_x) && (value_x < mean_x + dist1);
   assign in2 = (mean_x - dist2 < value_x) && (value_x < mean_x + dist2);
   assign in3 = (mean_x - dist3 < value_x) && (value_x < mean_x + dist3);
   assign beyond3 = (value_x < mean_x - dist3) || (value_x > mean_x + dist3);

   // Classify and hand the request to the queue.
   always_comb begin
      q_entry.sample_time = req_sample_time;
      q_entry.sample_value = req_sample_value;
      q_entry.keep_band = 1'b0;
      if (in1) begin
         q_entry.band = BandOne;
      end else if (in2) begin
         q_entry.band = BandTwo;
      end else if (in3) begin
         q_entry.band = BandThree;
      end else if (beyond3) begin
         q_entry.band = BandOutlier;
      end else begin
         q_entry.band = BandOne;
         q_entry.keep_band = 1'b1;
      end
   end

   assign q_push = push & ~q_stat.full;

endmodule

// File: rtl/sbrd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigma band run detector request queue
// A short first-in first-out queue of classified requests that lets the
// front end and the back end stall independently.
// ----------------------------------------------------------------------------
module sbrd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  sbrd_pkg::entry_type push_data,
   input  logic                pop_en,
   output sbrd_pkg::entry_type head,
   output sbrd_pkg::qstat_type stat
);
   import sbrd_pkg::*;

   entry_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff;
   logic [QueuePtrW-1:0]   wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff;
   logic [QueuePtrW-1:0]   rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff;
   logic [QueueCntW-1:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full = (count_ff == QueueCntW'(QueueDepth));
   assign do_push = push_en & ~stat.full;
   assign do_pop = pop_en & ~stat.empty;
   assign head = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/sbrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigma band run detector back end
// Tracks the current band, the run count and sum and the open run, and
// queues a record each time an open run closes.
// ----------------------------------------------------------------------------
module sbrd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sbrd_pkg::cfg_type    cfg,
   input  sbrd_pkg::entry_type  q_head,
   input  sbrd_pkg::qstat_type  q_stat,
   output logic                 q_pop,
   input  logic                 pop,
   output logic                 empty,
   output sbrd_pkg::result_type rsp
);
   import sbrd_pkg::*;

   localparam logic signed [47:0] AccMax = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] AccMin = {1'b1, {47{1'b0}}};

   // Run state.
   logic [1:0]          band_ff;
   logic [1:0]          band_in;
   logic [31:0]         count_ff;
   logic [31:0]         count_in;
   logic signed [47:0]  accum_ff;
   logic signed [47:0]  accum_in;
   logic [31:0]         start_ff;
   logic [31:0]         start_in;

   // Result queue.
   result_type            rslot_ff [QueueDepth];
   logic [QueuePtrW-1:0]  rwr_ptr_ff;
   logic [QueuePtrW-1:0]  rwr_ptr_in;
   logic [QueuePtrW-1:0]  rrd_ptr_ff;
   logic [QueuePtrW-1:0]  rrd_ptr_in;
   logic [QueueCntW-1:0]  rcount_ff;
   logic [QueueCntW-1:0]  rcount_in;

   logic                rsp_pop;
   logic                rsp_room;
   logic                step;
   logic                emit;
   logic                changed;
   logic [31:0]         base_count;
   logic signed [47:0]  base_accum;
   logic signed [48:0]  sum;
   logic [15:0]         limit;
   logic                opening;
   result_type          record;

   assign empty = (rcount_ff == '0);
   assign rsp_pop = pop & ~empty;
   assign rsp = rslot_ff[rrd_ptr_ff];
   assign rsp_room = (rcount_ff != QueueCntW'(QueueDepth)) | rsp_pop;
   assign step = ~q_stat.empty & rsp_room;
   assign q_pop = step;

   // Band of this request: a boundary sample keeps the previous band.
   assign band_in = q_head.keep_band ? band_ff : q_head.band;
   assign changed = (band_in != band_ff);
   assign base_count = changed ? '0 : count_ff;
   assign base_accum = changed ? '0 : accum_ff;
   assign count_in = (base_count == '1) ? base_count : base_count + 1'b1;
   assign sum = 49'(base_accum) + 49'(q_head.sample_value);

   // Saturate the run sum to the signed 48-bit range.
   always_comb begin
      if (sum[48] != sum[47]) begin
         accum_in = sum[48] ? AccMin : AccMax;
      end else begin
         accum_in = sum[47:0];
      end
   end

   // Decide whether the run is open after this request.
   always_comb begin
      case (band_in)
         BandOne:   limit = cfg.band1_run_limit;
         BandTwo:   limit = cfg.band2_run_limit;
         BandThree: limit = cfg.band3_run_limit;
         default:   limit = '0;
      endcase
      opening = (band_in == BandOutlier) || (count_in > 32'(limit));
   end

   // Open run stamping and closing.
   always_comb begin
      start_in = start_ff;
      emit = 1'b0;
      if (opening) begin
         if (start_ff == '0) begin
            start_in = q_head.sample_time;
         end
      end else if (start_ff != '0) begin
         start_in = '0;
         emit = 1'b1;
      end
   end

   assign record.run_start = start_ff;
   assign record.run_end = q_head.sample_time;
   assign record.run_kind = band_ff;
   assign record.run_readings = count_ff;
   assign record.run_total = accum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= BandOne;
         count_ff <= '0;
         accum_ff <= '0;
         start_ff <= '0;
      end else if (step) begin
         band_ff <= band_in;
         count_ff <= count_in;
         accum_ff <= accum_in;
         start_ff <= start_in;
      end
   end

   // Result queue pointers and fill count.
   always_comb begin
      rwr_ptr_in = rwr_ptr_ff;
      rrd_ptr_in = rrd_ptr_ff;
      rcount_in = rcount_ff;
      if (step && emit) begin
         rwr_ptr_in = (rwr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rwr_ptr_ff + 1'b1;
      end
      if (rsp_pop) begin
         rrd_ptr_in = (rrd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rrd_ptr_ff + 1'b1;
      end
      if ((step && emit) && !rsp_pop) begin
         rcount_in = rcount_ff + 1'b1;
      end else if (rsp_pop && !(step && emit)) begin
         rcount_in = rcount_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rwr_ptr_ff <= '0;
         rrd_ptr_ff <= '0;
         rcount_ff <= '0;
      end else begin
         rwr_ptr_ff <= rwr_ptr_in;
         rrd_ptr_ff <= rrd_ptr_in;
         rcount_ff <= rcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rslot_ff[rwr_ptr_ff] <= record;
      end
   end

endmodule

// File: rtl/sigma_band_run_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigma band run detector
// Classifies timestamped samples into sigma bands around a mean and reports
// each anomalous run of readings when it closes.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  request   push / full           req_sample_time, req_sample_value
//  result    empty / pop           rsp_run_start, rsp_run_end, rsp_run_kind,
//                                  rsp_run_readings, rsp_run_total
//  config    csr_write_en          csr_index, csr_data
//
// One request is taken every cycle while full is low; it is classified as it
// is accepted and waits in the request queue for the run tracker; its record,
// if any, waits in the result queue, whose head drives the result ports.
// The run tracker retires one request per cycle unless the result side stalls
// it; the two-entry queues only absorb stalls between front, back and results.
// Reset is synchronous; it empties the queues and closes any open run.
// A stalled result side fills the result queue and then the request queue,
// after which full is raised.
// ----------------------------------------------------------------------------
module sigma_band_run_detector_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [31:0]        req_sample_time,
   input  logic signed [31:0] req_sample_value,
   output logic               empty,
   input  logic               pop,
   output logic [31:0]        rsp_run_start,
   output logic [31:0]        rsp_run_end,
   output logic [1:0]         rsp_run_kind,
   output logic [31:0]        rsp_run_readings,
   output logic signed [47:0] rsp_run_total,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import sbrd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   entry_type  q_entry;
   entry_type  q_head;
   qstat_type  q_stat;
   logic       q_push;
   logic       q_pop;
   result_type rsp;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            RegMeanLevel:  cfg_in.mean_level = signed'(csr_data);
            RegBandSigma:  cfg_in.band_sigma = csr_data[30:0];
            RegBand1Limit: cfg_in.band1_run_limit = csr_data[15:0];
            RegBand2Limit: cfg_in.band2_run_limit = csr_data[15:0];
            RegBand3Limit: cfg_in.band3_run_limit = csr_data[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean_level <= '0;
         cfg_ff.band_sigma <= '0;
         cfg_ff.band1_run_limit <= Band1LimitReset;
         cfg_ff.band2_run_limit <= Band2LimitReset;
         cfg_ff.band3_run_limit <= Band3LimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept and classify.
   sbrd_front u_front (
      .cfg              (cfg_ff),
      .push             (push),
      .req_sample_time  (req_sample_time),
      .req_sample_value (req_sample_value),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   // Queue between front and back.
   sbrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (q_push),
      .push_data (q_entry),
      .pop_en    (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   // Back end: run tracking and result queue.
   sbrd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_head (q_head),
      .q_stat (q_stat),
      .q_pop  (q_pop),
      .pop    (pop),
      .empty  (empty),
      .rsp    (rsp)
   );

   assign full = q_stat.full;
   assign rsp_run_start = rsp.run_start;
   assign rsp_run_end = rsp.run_end;
   assign rsp_run_kind = rsp.run_kind;
   assign rsp_run_readings = rsp.run_readings;
   assign rsp_run_total = rsp.run_total;

endmodule

// File: test/sigma_band_run_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigma band run detector testbench
// Drives timestamped samples through the request queue and checks every run
// record against its typed row or a cycle-free tracker model in this file.
// A short table covers the band boundaries, the field extremes, zero
// timestamps and an outlier that extends a run. Random phases then reprogram
// the registers between bursts of band-shaped samples, with random gaps on
// both sides.
// ----------------------------------------------------------------------------
module sigma_band_run_detector_unit_tb;
   import sbrd_pkg::*;

   localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint AccMin = -AccMax - 1;
   localparam int DirectedRows = 28;
   localparam int RandomPhases = 12;
   localparam int PhaseItems = 140;
   localparam int SettleCycles = 10;
   localparam int unsigned CycleLimit = 2000000;

   typedef enum logic {RowSample, RowWrite} row_kind_type;

   // One line of the directed table: a sample, optionally with its record
   // typed in, or a register write.
   typedef struct packed {
      row_kind_type       kind;
      logic [2:0]         index;
      logic [31:0]        word;
      logic [31:0]        stamp;
      logic signed [31:0] value;
      logic               typed;
      result_type         want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [31:0]        req_sample_time = '0;
   logic signed [31:0] req_sample_value = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic [31:0]        rsp_run_start;
   logic [31:0]        rsp_run_end;
   logic [1:0]         rsp_run_kind;
   logic [31:0]        rsp_run_readings;
   logic signed [47:0] rsp_run_total;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   // Shadow of the registers and of the run tracker state.
   cfg_type            shadow_cfg;
   logic [1:0]         band_state;
   logic [31:0]        run_len;
   logic signed [47:0] run_sum;
   logic [31:0]        run_open_at;

   result_type         pending_runs[$];
   stim_row_type       directed_rows[DirectedRows];
   bit                 steady = 1'b0;
   int unsigned        error_count = 0;
   int unsigned        records_checked = 0;
   int unsigned        requests_sent = 0;
   int unsigned        reg_writes = 0;
   int unsigned        cycle_count = 0;
   logic [31:0]        stamp_now;

   sigma_band_run_detector_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_sample_time  (req_sample_time),
      .req_sample_value (req_sample_value),
      .empty            (empty),
      .pop              (pop),
      .rsp_run_start    (rsp_run_start),
      .rsp_run_end      (rsp_run_end),
      .rsp_run_kind     (rsp_run_kind),
      .rsp_run_readings (rsp_run_readings),
      .rsp_run_total    (rsp_run_total),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic flag_error(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_len();
      if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 4);
   endfunction

   // Register write as seen by the shadow configuration.
   task automatic apply_reg(input logic [2:0] index, input logic [31:0] word);
      case (index)
         RegMeanLevel: shadow_cfg.mean_level = word;
         RegBandSigma: shadow_cfg.band_sigma = word[30:0];
         RegBand1Limit: shadow_cfg.band1_run_limit = word[15:0];
         RegBand2Limit: shadow_cfg.band2_run_limit = word[15:0];
         RegBand3Limit: shadow_cfg.band3_run_limit = word[15:0];
         default: ;
      endcase
   endtask

   // Classifies one sample, updates the run and returns the record of a run
   // that closes on it.
   task automatic advance_tracker(input logic [31:0] stamp, input logic signed [31:0] value,
                                  output bit emits, output result_type rec);
      longint             centre;
      longint             width;
      longint             sample;
      longint             total;
      logic [1:0]         band;
      bit                 opening;
      logic [1:0]         prev_band;
      logic [31:0]        prev_len;
      logic signed [47:0] prev_sum;
      logic [31:0]        prev_open;
      centre = longint'($signed(shadow_cfg.mean_level));
      width = longint'({1'b0, shadow_cfg.band_sigma});
      sample = longint'(value);
      prev_band = band_state;
      prev_len = run_len;
      prev_sum = run_sum;
      prev_open = run_open_at;
      band = band_state;

      // Strict bands; a sample exactly on the outer bound keeps the old band.
      if (centre - width < sample && sample < centre + width) begin
         band = BandOne;
      end else if (centre - 2 * width < sample && sample < centre + 2 * width) begin
         band = BandTwo;
      end else if (centre - 3 * width < sample && sample < centre + 3 * width) begin
         band = BandThree;
      end else if (sample < centre - 3 * width || sample > centre + 3 * width) begin
         band = BandOutlier;
      end

      // A band change starts a fresh count and sum, both saturating.
      if (band != band_state) begin
         run_len = '0;
         run_sum = '0;
      end
      band_state = band;
      if (run_len != 32'hFFFF_FFFF) run_len = run_len + 1;
      total = longint'(run_sum) + sample;
      if (total > AccMax) total = AccMax;
      else if (total < AccMin) total = AccMin;
      run_sum = total[47:0];

      case (band)
         BandOutlier: opening = 1'b1;
         BandOne: opening = run_len > shadow_cfg.band1_run_limit;
         BandTwo: opening = run_len > shadow_cfg.band2_run_limit;
         default: opening = run_len > shadow_cfg.band3_run_limit;
      endcase

      emits = 1'b0;
      rec = '0;
      if (opening) begin
         if (run_open_at == '0) run_open_at = stamp;
      end else if (prev_open != '0) begin
         run_open_at = '0;
         emits = 1'b1;
         rec.run_start = prev_open;
         rec.run_end = stamp;
         rec.run_kind = prev_band;
         rec.run_readings = prev_len;
         rec.run_total = prev_sum;
      end
   endtask

   // Offers one request and waits until the block takes it.
   task automatic send_sample(input logic [31:0] stamp, input logic signed [31:0] value,
                              input bit typed, input result_type want);
      bit         emits;
      result_type rec;
      req_sample_time <= stamp;
      req_sample_value <= value;
      push <= 1'b1;
      do @(posedge clock); while (full);
      advance_tracker(stamp, value, emits, rec);
      if (typed) pending_runs.push_back(want);
      else if (emits) pending_runs.push_back(rec);
      requests_sent++;
   endtask

   task automatic maybe_pause();
      if (!steady && $urandom_range(0, 2) == 0) begin
         push <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   // The sender holds off until every outstanding record has been popped.
   task automatic hold_until_drained();
      push <= 1'b0;
      while (pending_runs.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Drained and settled, so that registers may change.
   task automatic wait_idle();
      push <= 1'b0;
      while (pending_runs.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] word);
      csr_index <= index;
      csr_data <= word;
      csr_write_en <= 1'b1;
      @(posedge clock);
      csr_write_en <= 1'b0;
      apply_reg(index, word);
      reg_writes++;
      @(posedge clock);
   endtask

   function automatic stim_row_type sample_row(input logic [31:0] stamp,
                                               input logic signed [31:0] value);
      stim_row_type row;
      row = '0;
      row.kind = RowSample;
      row.stamp = stamp;
      row.value = value;
      return row;
   endfunction

   function automatic stim_row_type record_row(input logic [31:0] stamp,
                                               input logic signed [31:0] value,
                                               input logic [31:0] start,
                                               input logic [1:0] kind,
                                               input logic [31:0] readings,
                                               input logic signed [47:0] total);
      stim_row_type row;
      row = sample_row(stamp, value);
      row.typed = 1'b1;
      row.want.run_start = start;
      row.want.run_end = stamp;
      row.want.run_kind = kind;
      row.want.run_readings = readings;
      row.want.run_total = total;
      return row;
   endfunction

   function automatic stim_row_type write_row(input logic [2:0] index, input logic [31:0] word);
      stim_row_type row;
      row = '0;
      row.kind = RowWrite;
      row.index = index;
      row.word = word;
      return row;
   endfunction

   // A sample near the given multiple of sigma: mostly inside the band,
   // sometimes exactly on its edge, sometimes anywhere at all.
   function automatic logic signed [31:0] band_sample(input int mult);
      longint centre;
      longint width;
      longint pick;
      int     sel;
      centre = longint'($signed(shadow_cfg.mean_level));
      width = longint'({1'b0, shadow_cfg.band_sigma});
      sel = $urandom_range(0, 9);
      if (sel == 0) return $urandom;
      if (sel == 1) pick = centre + (mult < -3 ? -3 : mult) * width;
      else pick = centre + mult * width + longint'($urandom) % (width + 1);
      if (pick > 64'sd2147483647) pick = 64'sd2147483647;
      if (pick < -64'sd2147483648) pick = -64'sd2147483648;
      return pick[31:0];
   endfunction

   function automatic logic [15:0] pick_limit(input int phase);
      if (phase == 1) return 16'hFFFF;
      if (phase == 2) return 16'h0000;
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 10));
   endfunction

   // New band and limit settings for one random phase; upper bits of the
   // write data are random and must be ignored.
   task automatic program_random_setup(input int phase);
      logic [31:0] word;
      wait_idle();
      if ($urandom_range(0, 3) == 0) word = $urandom;
      else word = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
      write_reg(RegMeanLevel, word);
      word = $urandom;
      case ($urandom_range(0, 9))
         0: word[30:0] = '0;
         1: ;
         default: word[30:0] = 31'($urandom_range(1, 1 << 18));
      endcase
      if (phase == 3) word[30:0] = '1;
      write_reg(RegBandSigma, word);
      word = $urandom;
      word[15:0] = pick_limit(phase);
      write_reg(RegBand1Limit, word);
      word = $urandom;
      word[15:0] = pick_limit(phase);
      write_reg(RegBand2Limit, word);
      word = $urandom;
      word[15:0] = pick_limit(phase);
      write_reg(RegBand3Limit, word);
      if ($urandom_range(0, 1) == 0) begin
         write_reg(3'($urandom_range(RegBand3Limit + 3'd1, 3'h7)), $urandom);
      end
   endtask

   // Result side: pop held high a while, then dropped for a gap unless steady.
   initial begin
      forever begin
         pop <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if (!steady) begin
            pop <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
      end
   end

   // Each popped record is compared with the oldest expected one.
   always @(posedge clock) begin
      result_type want;
      if (!reset && pop && !empty) begin
         if (pending_runs.size() == 0) begin
            flag_error("run record popped while none was expected");
         end else begin
            want = pending_runs.pop_front();
            records_checked++;
            if (rsp_run_start !== want.run_start)
               flag_error($sformatf("run_start %0h, expected %0h", rsp_run_start, want.run_start));
            if (rsp_run_end !== want.run_end)
               flag_error($sformatf("run_end %0h, expected %0h", rsp_run_end, want.run_end));
            if (rsp_run_kind !== want.run_kind)
               flag_error($sformatf("run_kind %0d, expected %0d", rsp_run_kind, want.run_kind));
            if (rsp_run_readings !== want.run_readings)
               flag_error($sformatf("run_readings %0d, expected %0d", rsp_run_readings,
                                    want.run_readings));
            if (rsp_run_total !== want.run_total)
               flag_error($sformatf("run_total %0d, expected %0d", rsp_run_total,
                                    want.run_total));
         end
      end
   end

   // Watchdog.
   initial begin
      wait (cycle_count >= CycleLimit);
      $display("Timed out after %0d cycles with %0d records outstanding", cycle_count,
               pending_runs.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // Main sequence.
   initial begin
      int         mult;
      int         run_left;
      int         left;
      result_type no_record;
      no_record = '0;
      shadow_cfg = '0;
      shadow_cfg.band1_run_limit = Band1LimitReset;
      shadow_cfg.band2_run_limit = Band2LimitReset;
      shadow_cfg.band3_run_limit = Band3LimitReset;
      band_state = BandOne;
      run_len = '0;
      run_sum = '0;
      run_open_at = '0;

      // Boundaries, extremes, zero timestamps and an outlier extending a run.
      directed_rows = '{
         sample_row(32'd100, 32'sh0001_0000),
         sample_row(32'd101, 32'sh0000_0000),
         sample_row(32'd0, 32'sh8000_0000),
         write_row(RegBandSigma, 32'h8001_0000),
         write_row(RegBand1Limit, 32'hFFFF_FFFF),
         record_row(32'd200, 32'sh0000_0000, 32'd100, BandOutlier, 32'd3, -48'sd2147418112),
         sample_row(32'd201, 32'sh7FFF_FFFF),
         record_row(32'd202, 32'sh0001_0000, 32'd201, BandOutlier, 32'd1, 48'sd2147483647),
         sample_row(32'd203, 32'sh0003_0000),
         sample_row(32'd204, -32'sh0003_0000),
         sample_row(32'd205, 32'sh0002_0000),
         write_row(RegBand3Limit, 32'h0000_0000),
         write_row(RegBand2Limit, 32'hABCD_0000),
         sample_row(32'd300, 32'sh0002_8000),
         sample_row(32'd301, 32'sh0004_0000),
         record_row(32'd302, 32'sh0000_0000, 32'd300, BandOutlier, 32'd1, 48'sd262144),
         sample_row(32'd0, 32'sh0005_0000),
         sample_row(32'd400, 32'sh0000_0000),
         write_row(RegMeanLevel, 32'h8000_0000),
         write_row(RegBandSigma, 32'h7FFF_FFFF),
         sample_row(32'd401, 32'sh8000_0000),
         sample_row(32'd402, 32'sh7FFF_FFFF),
         write_row(RegMeanLevel, 32'h7FFF_FFFF),
         write_row(RegBandSigma, 32'h0000_0001),
         sample_row(32'd403, 32'sh8000_0000),
         sample_row(32'd404, 32'sh7FFF_FFFF),
         sample_row(32'hFFFF_FFFF, 32'sh7FFF_FFFE),
         sample_row(32'd405, 32'sh7FFF_FFFF)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == RowWrite) begin
            wait_idle();
            write_reg(directed_rows[i].index, directed_rows[i].word);
         end else begin
            send_sample(directed_rows[i].stamp, directed_rows[i].value,
                        directed_rows[i].typed, directed_rows[i].want);
            maybe_pause();
         end
      end

      // Random phases: stretches of samples that stay near one band so that
      // runs grow past their limits, with an occasional stray timestamp.
      stamp_now = 32'd1000;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         program_random_setup(phase);
         steady = (phase % 4 == 3);
         left = PhaseItems;
         while (left > 0) begin
            mult = int'($urandom_range(0, 7)) - 4;
            run_left = $urandom_range(1, 24);
            while (run_left > 0 && left > 0) begin
               case ($urandom_range(0, 39))
                  0: stamp_now = $urandom;
                  1: stamp_now = '0;
                  default: stamp_now = stamp_now + $urandom_range(1, 4);
               endcase
               send_sample(stamp_now, band_sample(mult), 1'b0, no_record);
               run_left--;
               left--;
               if (left == PhaseItems / 2) hold_until_drained();
               else maybe_pause();
            end
         end
         steady = 1'b0;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests (directed table and %0d random phases)",
               requests_sent, RandomPhases);
      $display("Checked %0d run records after %0d register writes", records_checked,
               reg_writes);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/sbrd_pkg.sv
rtl/sbrd_front.sv
rtl/sbrd_queue.sv
rtl/sbrd_back.sv
rtl/sigma_band_run_detector_unit.sv
test/sigma_band_run_detector_unit_tb.sv
